// ----- sv/mwa_pkg.sv -----
package mwa_pkg;

	localparam int LEN_W    = 11;
	localparam int SUM_W    = 27;
	localparam int MAXSUM_W = 26;
	localparam int AVG_W    = 36;
	localparam int FRAC_W   = 20;
	localparam int DVD_W    = MAXSUM_W + FRAC_W;

	typedef logic [LEN_W-1:0]           len_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [MAXSUM_W-1:0] max_sum_t;
	typedef logic signed [AVG_W-1:0]    avg_t;
	typedef logic [DVD_W-1:0]           dvd_t;

	localparam max_sum_t MAXSUM_POS = {1'b0, {(MAXSUM_W-1){1'b1}}};
	localparam max_sum_t MAXSUM_NEG = {1'b1, {(MAXSUM_W-1){1'b0}}};
	localparam avg_t     AVG_POS    = {1'b0, {(AVG_W-1){1'b1}}};
	localparam avg_t     AVG_NEG    = {1'b1, {(AVG_W-1){1'b0}}};
	// magnitude of the most negative average
	localparam dvd_t     AVG_LIM    = DVD_W'(1) << (AVG_W - 1);

endpackage

// ----- sv/mwa_if.sv -----
interface mwa_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface mwa_out_if;
	logic                        valid;
	logic                        ready;
	logic signed [26-1:0]        max_sum;
	logic signed [36-1:0]        average;
	logic                        window_ok;

	modport source (output valid, output max_sum, output average, output window_ok,
		input ready);
	modport sink   (input valid, input max_sum, input average, input window_ok,
		output ready);
endinterface

interface mwa_cfg_if;
	logic        valid;
	logic        ready;
	logic [10:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/mwa_ring.sv -----
module mwa_ring #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the entry as it was before a write in the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/mwa_div.sv -----
module mwa_div #(
	parameter int DVS_W = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  mwa_pkg::dvd_t           dividend,
	input  logic [DVS_W-1:0]        divisor,
	output logic                    done,
	output mwa_pkg::dvd_t           quotient
);
	import mwa_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	dvd_t              quo_q;
	logic [DVS_W:0]    rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    trial;
	logic              fits;

	assign trial = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/max_window_average_top.sv -----
// channel   dir  handshake     payload
// samples   in   valid/ready   sample, last
// results   out  valid/ready   max_sum, average, window_ok
// cfg       in   valid/ready   data (window_len), always ready
//
// Each sample request goes through accept with ring write and read of the
// leaving sample, sum update and best-sum compare; none is accepted meanwhile.
// A last sample on a full window adds a clamp state and the bit-serial
// divider (46 steps, then done); any last sample then fills the result register.
// Reset clears control and stream state; the sample ring is never cleared.
// A result waits in its register; a following last sample stalls only until it
// is taken.
module max_window_average_top #(
	parameter int WINDOW_MAX  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	mwa_in_if.sink            samples,
	mwa_out_if.source         results,
	mwa_cfg_if.sink           cfg
);
	import mwa_pkg::*;

	localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_BEST,
		S_CLAMP,
		S_DIV,
		S_OUT
	} state_t;

	state_t                        state_q;
	len_t                          window_len_q;
	logic [PTR_W-1:0]              ptr_q;
	logic [CNT_W-1:0]              seen_q;
	sum_t                          window_sum_q;
	sum_t                          best_q;
	logic                          have_best_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          last_q;
	logic                          full_pre_q;
	logic                          full_post_q;
	max_sum_t                      ms_q;
	logic                          res_valid_q;
	max_sum_t                      res_max_sum_q;
	avg_t                          res_average_q;
	logic                          res_ok_q;

	logic [CNT_W-1:0]              eff_len;
	logic [CNT_W:0]                diff;
	logic [CNT_W:0]                wrap;
	logic [PTR_W-1:0]              old_idx;
	logic [CNT_W-1:0]              seen_nxt;
	logic                          accept;
	logic signed [SAMPLE_BITS-1:0] old_sample;
	max_sum_t                      ms;
	max_sum_t                      mag;
	dvd_t                          dividend;
	logic                          div_start;
	logic                          div_done;
	dvd_t                          quo;
	dvd_t                          quo_neg;
	avg_t                          avg;
	logic                          out_free;

	always_comb begin
		if (window_len_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(window_len_q) > WINDOW_MAX) begin
			eff_len = CNT_W'(WINDOW_MAX);
		end else begin
			eff_len = CNT_W'(window_len_q);
		end
	end

	// slot of the sample that leaves the window, modulo the ring depth
	assign diff     = (CNT_W+1)'(ptr_q) - (CNT_W+1)'(eff_len);
	assign wrap     = diff[CNT_W] ? diff + (CNT_W+1)'(WINDOW_MAX) : diff;
	assign old_idx  = wrap[PTR_W-1:0];
	assign seen_nxt = (32'(seen_q) < WINDOW_MAX) ? seen_q + CNT_W'(1) : seen_q;

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign cfg.ready     = 1'b1;

	mwa_ring #(
		.DEPTH (WINDOW_MAX),
		.WIDTH (SAMPLE_BITS),
		.AW    (PTR_W)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (ptr_q),
		.wdata (samples.sample),
		.raddr (old_idx),
		.rdata (old_sample)
	);

	// saturate the best sum to the result width
	always_comb begin
		if (!best_q[SUM_W-1] && best_q[SUM_W-2]) begin
			ms = MAXSUM_POS;
		end else if (best_q[SUM_W-1] && !best_q[SUM_W-2]) begin
			ms = MAXSUM_NEG;
		end else begin
			ms = best_q[MAXSUM_W-1:0];
		end
	end

	assign mag       = ms[MAXSUM_W-1] ? (MAXSUM_W'(0) - ms) : ms;
	assign dividend  = {mag, {FRAC_W{1'b0}}};
	assign div_start = (state_q == S_CLAMP);

	mwa_div #(
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (eff_len),
		.done     (div_done),
		.quotient (quo)
	);

	assign quo_neg = DVD_W'(0) - quo;

	always_comb begin
		if (ms_q[MAXSUM_W-1]) begin
			avg = (quo > AVG_LIM) ? AVG_NEG : quo_neg[AVG_W-1:0];
		end else begin
			avg = (quo >= AVG_LIM) ? AVG_POS : quo[AVG_W-1:0];
		end
	end

	assign out_free = !res_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			window_len_q <= LEN_W'(1);
			ptr_q        <= '0;
			seen_q       <= '0;
			window_sum_q <= '0;
			best_q       <= '0;
			have_best_q  <= 1'b0;
			last_q       <= 1'b0;
			full_pre_q   <= 1'b0;
			full_post_q  <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				window_len_q <= cfg.data;
			end
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && results.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q      <= samples.last;
						full_pre_q  <= seen_q >= eff_len;
						full_post_q <= seen_nxt >= eff_len;
						seen_q      <= seen_nxt;
						ptr_q       <= (32'(ptr_q) == WINDOW_MAX - 1) ? '0 : ptr_q + PTR_W'(1);
						state_q     <= S_SUM;
					end
				end
				S_SUM: begin
					window_sum_q <= window_sum_q + SUM_W'(sample_q)
						- (full_pre_q ? SUM_W'(old_sample) : SUM_W'(0));
					state_q <= S_BEST;
				end
				S_BEST: begin
					if (full_post_q) begin
						if (!have_best_q || window_sum_q > best_q) begin
							best_q <= window_sum_q;
						end
						have_best_q <= 1'b1;
					end
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (full_post_q) begin
						state_q <= S_CLAMP;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_CLAMP: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the result register is free, then drop stream state
					if (out_free) begin
						ptr_q        <= '0;
						seen_q       <= '0;
						window_sum_q <= '0;
						best_q       <= '0;
						have_best_q  <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= samples.sample;
		end
		if (state_q == S_CLAMP) begin
			ms_q <= ms;
		end
		if (state_q == S_OUT && out_free) begin
			res_ok_q      <= full_post_q;
			res_max_sum_q <= full_post_q ? ms_q : '0;
			res_average_q <= full_post_q ? avg : '0;
		end
	end

	assign results.valid     = res_valid_q;
	assign results.max_sum   = res_max_sum_q;
	assign results.average   = res_average_q;
	assign results.window_ok = res_ok_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import mwa_pkg::*;

	localparam int          RING_DEPTH      = 1024;
	localparam int          DRAIN_CYCLES    = 64;
	localparam int          ITEMS_PER_PHASE = 64;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam longint      MAXSUM_HI       = (longint'(1) << (MAXSUM_W - 1)) - 1;
	localparam longint      MAXSUM_LO       = -(longint'(1) << (MAXSUM_W - 1));
	localparam longint      AVG_HI          = (longint'(1) << (AVG_W - 1)) - 1;
	localparam longint      AVG_LO          = -(longint'(1) << (AVG_W - 1));

	typedef enum int {MIX_FULL, MIX_RAILS, MIX_HIGH, MIX_LOW, MIX_SMALL} sample_mix_e;

	typedef struct {
		max_sum_t max_sum;
		avg_t     average;
		logic     window_ok;
	} window_result_t;

	class window_scoreboard;
		logic signed [15:0] ring [RING_DEPTH];
		sum_t               run_sum;
		sum_t               top_sum;
		bit                 have_top;
		int unsigned        filled;
		int unsigned        wr_ptr;
		len_t               win_len = 1;
		window_result_t     expected_q [$];
		int                 errors;

		function int unsigned eff_len();
			if (win_len == 0)
				return 1;
			if (win_len > RING_DEPTH)
				return RING_DEPTH;
			return win_len;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_sample(logic signed [15:0] s, logic is_last);
			int unsigned    len;
			longint         ms;
			longint         mag;
			longint         avg;
			window_result_t r;
			len = eff_len();
			// drop the sample leaving the window, with wrap at the sum width
			run_sum = run_sum + sum_t'(s);
			if (filled >= len)
				run_sum = run_sum - sum_t'(ring[(wr_ptr + RING_DEPTH - len) % RING_DEPTH]);
			ring[wr_ptr] = s;
			wr_ptr = (wr_ptr + 1) % RING_DEPTH;
			if (filled < RING_DEPTH)
				filled++;
			if (filled >= len) begin
				if (!have_top || run_sum > top_sum)
					top_sum = run_sum;
				have_top = 1'b1;
			end
			if (!is_last)
				return;
			if (filled >= len && have_top) begin
				ms = top_sum;
				if (ms > MAXSUM_HI)
					ms = MAXSUM_HI;
				else if (ms < MAXSUM_LO)
					ms = MAXSUM_LO;
				mag = (ms < 0) ? -ms : ms;
				avg = (mag << FRAC_W) / longint'(len);
				if (ms < 0)
					avg = -avg;
				if (avg > AVG_HI)
					avg = AVG_HI;
				else if (avg < AVG_LO)
					avg = AVG_LO;
				r.max_sum   = max_sum_t'(ms);
				r.average   = avg_t'(avg);
				r.window_ok = 1'b1;
			end else begin
				r.max_sum   = '0;
				r.average   = '0;
				r.window_ok = 1'b0;
			end
			expected_q.push_back(r);
			run_sum  = '0;
			top_sum  = '0;
			have_top = 1'b0;
			filled   = 0;
			wr_ptr   = 0;
		endfunction

		function void report(string field, logic signed [63:0] exp_v, logic signed [63:0] act_v);
			errors++;
			if (errors <= 30)
				$display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
		endfunction

		function void check_result(max_sum_t ms, avg_t av, logic ok);
			window_result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 30)
					$display("%0t: unexpected result max_sum %0d average %0d window_ok %0b",
						$time, ms, av, ok);
				return;
			end
			e = expected_q.pop_front();
			if (ms !== e.max_sum)
				report("max_sum", e.max_sum, ms);
			if (av !== e.average)
				report("average", e.average, av);
			if (ok !== e.window_ok)
				report("window_ok", e.window_ok, ok);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mwa_in_if #(.SAMPLE_BITS(16)) samples ();
	mwa_out_if                    results ();
	mwa_cfg_if                    cfg ();

	max_window_average_top #(.WINDOW_MAX(RING_DEPTH), .SAMPLE_BITS(16)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg)
	);

	window_scoreboard sb = new();
	int               src_idle_pct;
	int               sink_stall_pct;
	int unsigned      cycles;
	int               src_idle_tbl  [4] = '{0, 59, 0, 34};
	int               sink_stall_tbl[4] = '{0, 0, 59, 34};

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (cycles == CYCLE_LIMIT) begin
			$display("** max_window_average_top: FAILED **");
			$finish;
		end else
			cycles <= cycles + 1;
	end

	always @(posedge clk) begin
		if (arst_n && results.valid === 1'b1 && results.ready)
			sb.check_result(results.max_sum, results.average, results.window_ok);
		results.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	task automatic push_sample(input logic signed [15:0] s, input logic is_last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid  <= 1'b1;
		samples.sample <= s;
		samples.last   <= is_last;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		sb.note_sample(s, is_last);
	endtask

	// hold until every result is in and the pipeline has drained
	task automatic hold_until_idle();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input len_t v);
		hold_until_idle();
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		sb.win_len = v;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample(sample_mix_e mix);
		case (mix)
			MIX_FULL:  return 16'($urandom);
			MIX_RAILS: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			MIX_HIGH:  return 16'(32767 - $urandom_range(0, 15));
			MIX_LOW:   return 16'(-32768 + int'($urandom_range(0, 15)));
			default:   return 16'(int'($urandom_range(0, 8)) - 4);
		endcase
	endfunction

	task automatic send_run(input int count, input sample_mix_e mix, input logic close);
		for (int i = 0; i < count; i++)
			push_sample(pick_sample(mix), close && (i == count - 1));
	endtask

	function automatic len_t pick_window();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return len_t'($urandom_range(1, 8));
		if (r < 78)
			return len_t'($urandom_range(9, 40));
		if (r < 90)
			return len_t'($urandom_range(41, 96));
		return '0;
	endfunction

	// mostly complete windows, some streams that end too early
	function automatic int plan_stream(int unsigned len);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15 && len > 1)
			return $urandom_range(1, len - 1);
		if (r < 30)
			return len;
		return len + $urandom_range(1, 24);
	endfunction

	initial begin
		int          ph;
		int          n;
		int          k;
		int          done_items;
		sample_mix_e mix;

		arst_n         = 1'b0;
		samples.valid  = 1'b0;
		samples.sample = '0;
		samples.last   = 1'b0;
		cfg.valid      = 1'b0;
		cfg.data       = '0;
		results.ready  = 1'b0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-sample streams at the reset length, both rails
		push_sample(16'sh7fff, 1'b1);
		push_sample(16'sh8000, 1'b1);
		// too few samples for the window, then a stream that fills it
		set_window(11'd3);
		push_sample(16'sd5, 1'b0);
		push_sample(-16'sd7, 1'b1);
		push_sample(16'sh7fff, 1'b0);
		push_sample(-16'sd1, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sd100, 1'b1);
		// length zero acts as one
		set_window(11'd0);
		push_sample(-16'sd2, 1'b0);
		push_sample(16'sd3, 1'b1);
		// shrink the window mid-stream so the average saturates high, then low
		set_window(11'd2);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		set_window(11'd1);
		push_sample(16'sh7fff, 1'b1);
		set_window(11'd2);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh8000, 1'b0);
		set_window(11'd1);
		push_sample(16'sh8000, 1'b1);
		// length above the ring depth acts as the depth
		set_window(11'd2047);
		push_sample(16'sd1, 1'b0);
		push_sample(-16'sd1, 1'b0);
		push_sample(16'sd0, 1'b1);

		// fill the whole ring at length one, then grow to the ring depth so max_sum
		// runs past its range
		src_idle_pct   = 34;
		sink_stall_pct = 34;
		set_window(11'd1);
		repeat (RING_DEPTH) push_sample(16'sh8000, 1'b0);
		set_window(11'd1024);
		repeat (512) push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh7fff, 1'b1);

		for (ph = 0; ph < 4; ph++) begin
			src_idle_pct   = src_idle_tbl[ph];
			sink_stall_pct = sink_stall_tbl[ph];
			done_items     = 0;
			while (done_items < ITEMS_PER_PHASE) begin
				set_window(pick_window());
				repeat ($urandom_range(2, 6)) begin
					n   = plan_stream(sb.eff_len());
					mix = sample_mix_e'($urandom_range(0, 4));
					if ($urandom_range(0, 9) == 0 && n > 1) begin
						k = $urandom_range(1, n - 1);
						send_run(k, mix, 1'b0);
						set_window(len_t'($urandom_range(1, 16)));
						send_run(n - k, mix, 1'b1);
					end else
						send_run(n, mix, 1'b1);
					done_items += n;
				end
			end
		end

		hold_until_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** max_window_average_top: PASSED **");
		else
			$display("** max_window_average_top: FAILED **");
		$finish;
	end

endmodule

// ----- max_window_average_top.f -----
sv/mwa_pkg.sv
sv/mwa_if.sv
sv/mwa_ring.sv
sv/mwa_div.sv
sv/max_window_average_top.sv
tb/tb.sv
